FILE: hw/rtl/vpd_pkg.sv
// Shared types and constants for the varint part deframer.
// Used by varint_part_deframer_core; depends on nothing.
package vpd_pkg;

  localparam int unsigned LENGTH_BITS = 32;

  localparam logic [2:0] KIND_MEDIA          = 3'd0;
  localparam logic [2:0] KIND_REDIRECT_RESET = 3'd1;
  localparam logic [2:0] KIND_REDIRECT_BYTE  = 3'd2;
  localparam logic [2:0] KIND_STATUS         = 3'd3;
  localparam logic [2:0] KIND_END            = 3'd4;

  localparam logic [31:0] TYPE_MEDIA    = 32'd21;
  localparam logic [31:0] TYPE_REDIRECT = 32'd43;
  localparam logic [31:0] TYPE_STATUS   = 32'd58;

  localparam logic [7:0] KEY_FIELD1_LEN = 8'h0a;
  localparam logic [3:0] PROTO_MAX_BYTES = 4'd10;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_TYPE    = 4'b0001,
    PH_SIZE    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_IGNORE  = 4'b1000
  } frame_phase_t;

  typedef enum logic [4:0] {
    IN_KEY    = 5'b00001,
    IN_VALUE  = 5'b00010,
    IN_LENGTH = 5'b00100,
    IN_BODY   = 5'b01000,
    IN_DONE   = 5'b10000
  } inner_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] status;
    logic        comp;
    logic        last;
  } result_t;

endpackage

FILE: hw/rtl/varint_part_deframer_core.sv
// Varint part deframer: splits a byte-wise response into media, redirect
// and status parts. Depends on vpd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per response byte, with
//   data_byte and bytes_remaining (zero marks the last byte of a response).
//   Output channel (out_valid/out_ready): result requests carrying
//   result_kind, out_byte, status_value, complete and last_result.
//   Each byte yields zero, one or two results; last_result flags the last
//   result of a byte.
// Results of a byte are registered into the queue when the byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the parse state is updated
//   by short logic in the cycle of acceptance and results go to a four-entry queue.
// Stall: in_ready drops while the queue holds three or more results, so a
//   stalled receiver backs up to the input once three results are waiting;
//   bytes that yield no result are still accepted until then.
// Reset: rst (synchronous, active high) empties the queue and returns the
//   parser to the start of a response, marked complete. The parser also
//   returns to that state after every last byte.
module varint_part_deframer_core
  import vpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        bytes_remaining,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         result_kind,
  output logic [7:0]         out_byte,
  output logic signed [31:0] status_value,
  output logic               complete,
  output logic               last_result
);

  frame_phase_t frame_phase, frame_phase_next;
  logic [31:0]  outer_value, outer_value_next;
  logic [2:0]   outer_left, outer_left_next;
  logic [2:0]   outer_len, outer_len_next;
  logic [31:0]  part_type, part_type_next;
  logic [31:0]  payload_left, payload_left_next;
  logic         past_first, past_first_next;
  inner_phase_t inner_phase, inner_phase_next;
  logic [63:0]  inner_value, inner_value_next;
  logic [3:0]   inner_count, inner_count_next;
  logic         key_one, key_one_next;
  logic [31:0]  skip_left, skip_left_next;
  logic         resp_ok, resp_ok_next;

  logic accept;
  assign accept = in_valid && in_ready;

  // prefix-length varint step
  logic [2:0]  o_first_len;
  logic        o_trunc, o_done;
  logic [31:0] o_value;
  logic [2:0]  o_left, o_len;
  logic [2:0]  o_pos;
  logic [3:0]  o_base;
  logic [5:0]  o_sh;

  always_comb begin
    priority if (data_byte < 8'd128) o_first_len = 3'd1;
    else if (data_byte < 8'd192) o_first_len = 3'd2;
    else if (data_byte < 8'd224) o_first_len = 3'd3;
    else if (data_byte < 8'd240) o_first_len = 3'd4;
    else o_first_len = 3'd5;
    o_pos  = outer_len - outer_left;
    o_base = (outer_len >= 3'd5) ? 4'd0 : 4'd8 - {1'b0, outer_len};
    o_sh   = 6'({2'b0, o_base} + {o_pos - 3'd1, 3'b000});
    o_trunc = 1'b0;
    o_value = outer_value;
    o_left  = outer_left;
    o_len   = outer_len;
    if (outer_left == 3'd0) begin
      if (32'(o_first_len - 3'd1) > bytes_remaining) begin
        o_trunc = 1'b1;
      end else begin
        o_len  = o_first_len;
        o_left = o_first_len - 3'd1;
        if (o_first_len == 3'd1) o_value = {24'd0, data_byte};
        else if (o_first_len == 3'd5) o_value = 32'd0;
        else o_value = {24'd0, data_byte & (8'hff >> o_first_len)};
      end
    end else begin
      o_value = outer_value | (32'(data_byte) << o_sh[4:0]);
      o_left  = outer_left - 3'd1;
    end
    o_done = !o_trunc && (o_left == 3'd0);
  end

  // protobuf varint step
  logic        p_fail, p_done;
  logic [63:0] p_value;
  logic [3:0]  p_count;
  logic [6:0]  p_sh;

  always_comb begin
    p_sh    = 7'(7 * inner_count);
    p_value = inner_value | (64'(data_byte[6:0]) << p_sh[5:0]);
    p_count = inner_count + 4'd1;
    p_fail  = 1'b0;
    p_done  = 1'b0;
    if (inner_count >= PROTO_MAX_BYTES) begin
      p_fail  = 1'b1;
      p_value = inner_value;
      p_count = inner_count;
    end else if (!data_byte[7]) begin
      p_done = 1'b1;
    end else if (p_count >= PROTO_MAX_BYTES) begin
      p_fail = 1'b1;
    end
  end

  logic        d_valid;
  logic [2:0]  d_kind;
  logic [7:0]  d_byte;
  logic [31:0] d_status;
  logic        e_valid, e_comp;
  logic [31:0] rem;
  logic        len_too_big;

  always_comb begin
    frame_phase_next  = frame_phase;
    outer_value_next  = outer_value;
    outer_left_next   = outer_left;
    outer_len_next    = outer_len;
    part_type_next    = part_type;
    payload_left_next = payload_left;
    past_first_next   = past_first;
    inner_phase_next  = inner_phase;
    inner_value_next  = inner_value;
    inner_count_next  = inner_count;
    key_one_next      = key_one;
    skip_left_next    = skip_left;
    resp_ok_next      = resp_ok;
    d_valid  = 1'b0;
    d_kind   = KIND_MEDIA;
    d_byte   = 8'd0;
    d_status = 32'd0;
    rem      = payload_left - 32'd1;
    if (LENGTH_BITS >= 32) len_too_big = 1'b0;
    else len_too_big = (64'(o_value) >> LENGTH_BITS) != 64'd0;

    unique case (frame_phase)
      PH_TYPE, PH_SIZE: begin
        outer_value_next = o_value;
        outer_left_next  = o_left;
        outer_len_next   = o_len;
        if (o_trunc) begin
          resp_ok_next     = 1'b0;
          frame_phase_next = PH_IGNORE;
          outer_left_next  = 3'd0;
        end else if (o_done) begin
          outer_value_next = 32'd0;
          if (frame_phase == PH_TYPE) begin
            part_type_next   = o_value;
            frame_phase_next = PH_SIZE;
          end else if (o_value > bytes_remaining || len_too_big) begin
            resp_ok_next     = 1'b0;
            frame_phase_next = PH_IGNORE;
          end else begin
            payload_left_next = o_value;
            past_first_next   = 1'b0;
            inner_phase_next  = IN_KEY;
            inner_value_next  = 64'd0;
            inner_count_next  = 4'd0;
            key_one_next      = 1'b0;
            skip_left_next    = 32'd0;
            if (part_type == TYPE_REDIRECT) begin
              d_valid = 1'b1;
              d_kind  = KIND_REDIRECT_RESET;
            end
            frame_phase_next = (o_value != 32'd0) ? PH_PAYLOAD : PH_TYPE;
          end
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = rem;
        past_first_next   = 1'b1;
        if (part_type == TYPE_MEDIA) begin
          if (past_first) begin
            d_valid = 1'b1;
            d_kind  = KIND_MEDIA;
            d_byte  = data_byte;
          end
        end else if (part_type == TYPE_REDIRECT) begin
          unique case (inner_phase)
            IN_KEY: begin
              inner_value_next = 64'd0;
              inner_count_next = 4'd0;
              inner_phase_next = (data_byte == KEY_FIELD1_LEN) ? IN_LENGTH : IN_DONE;
            end
            IN_LENGTH: begin
              inner_value_next = p_value;
              inner_count_next = p_count;
              if (p_fail) begin
                inner_phase_next = IN_DONE;
              end else if (p_done) begin
                inner_value_next = 64'd0;
                inner_count_next = 4'd0;
                if (p_value == 64'd0 || p_value > 64'(rem)) begin
                  inner_phase_next = IN_DONE;
                end else begin
                  skip_left_next   = p_value[31:0];
                  inner_phase_next = IN_BODY;
                end
              end
            end
            IN_BODY: begin
              d_valid = 1'b1;
              d_kind  = KIND_REDIRECT_BYTE;
              d_byte  = data_byte;
              skip_left_next = skip_left - 32'd1;
              if (skip_left == 32'd1) inner_phase_next = IN_DONE;
            end
            default: ;
          endcase
        end else if (part_type == TYPE_STATUS) begin
          unique case (inner_phase)
            IN_KEY, IN_VALUE, IN_LENGTH: begin
              inner_value_next = p_value;
              inner_count_next = p_count;
              if (p_fail) begin
                inner_phase_next = IN_DONE;
              end else if (p_done) begin
                inner_value_next = 64'd0;
                inner_count_next = 4'd0;
                if (inner_phase == IN_KEY) begin
                  if (p_value[2:0] == 3'd0) begin
                    key_one_next     = (p_value[63:3] == 61'd1);
                    inner_phase_next = IN_VALUE;
                  end else if (p_value[2:0] == 3'd2) begin
                    inner_phase_next = IN_LENGTH;
                  end else begin
                    inner_phase_next = IN_DONE;
                  end
                end else if (inner_phase == IN_VALUE) begin
                  if (key_one) begin
                    d_valid  = 1'b1;
                    d_kind   = KIND_STATUS;
                    d_status = p_value[31:0];
                    inner_phase_next = IN_DONE;
                  end else begin
                    inner_phase_next = IN_KEY;
                  end
                end else begin
                  if (p_value > 64'(rem)) begin
                    inner_phase_next = IN_DONE;
                  end else if (p_value == 64'd0) begin
                    inner_phase_next = IN_KEY;
                  end else begin
                    skip_left_next   = p_value[31:0];
                    inner_phase_next = IN_BODY;
                  end
                end
              end
            end
            IN_BODY: begin
              skip_left_next = skip_left - 32'd1;
              if (skip_left == 32'd1) inner_phase_next = IN_KEY;
            end
            default: ;
          endcase
        end
        if (rem == 32'd0) frame_phase_next = PH_TYPE;
      end
      default: ;
    endcase

    e_valid = (bytes_remaining == 32'd0);
    e_comp  = resp_ok_next && (frame_phase_next == PH_TYPE) && (outer_left_next == 3'd0);
    if (e_valid) begin
      frame_phase_next  = PH_TYPE;
      outer_value_next  = 32'd0;
      outer_left_next   = 3'd0;
      outer_len_next    = 3'd0;
      part_type_next    = 32'd0;
      payload_left_next = 32'd0;
      past_first_next   = 1'b0;
      inner_phase_next  = IN_KEY;
      inner_value_next  = 64'd0;
      inner_count_next  = 4'd0;
      key_one_next      = 1'b0;
      skip_left_next    = 32'd0;
      resp_ok_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase  <= PH_TYPE;
      outer_value  <= 32'd0;
      outer_left   <= 3'd0;
      outer_len    <= 3'd0;
      part_type    <= 32'd0;
      payload_left <= 32'd0;
      past_first   <= 1'b0;
      inner_phase  <= IN_KEY;
      inner_value  <= 64'd0;
      inner_count  <= 4'd0;
      key_one      <= 1'b0;
      skip_left    <= 32'd0;
      resp_ok      <= 1'b1;
    end else if (accept) begin
      frame_phase  <= frame_phase_next;
      outer_value  <= outer_value_next;
      outer_left   <= outer_left_next;
      outer_len    <= outer_len_next;
      part_type    <= part_type_next;
      payload_left <= payload_left_next;
      past_first   <= past_first_next;
      inner_phase  <= inner_phase_next;
      inner_value  <= inner_value_next;
      inner_count  <= inner_count_next;
      key_one      <= key_one_next;
      skip_left    <= skip_left_next;
      resp_ok      <= resp_ok_next;
    end
  end

  // result queue
  result_t    queue [QUEUE_DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  result_t    r_data, r_end, w0, w1;
  logic [1:0] n_push;
  logic       pop;

  always_comb begin
    r_data = '{kind: d_kind, data: d_byte, status: d_status, comp: 1'b0, last: !e_valid};
    r_end  = '{kind: KIND_END, data: 8'd0, status: 32'd0, comp: e_comp, last: 1'b1};
    w0     = d_valid ? r_data : r_end;
    w1     = r_end;
    n_push = accept ? ({1'b0, d_valid} + {1'b0, e_valid}) : 2'd0;
  end

  assign in_ready  = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, n_push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) queue[wr_ptr] <= w0;
    if (n_push == 2'd2) queue[wr_ptr + 2'd1] <= w1;
  end

  assign result_kind  = queue[rd_ptr].kind;
  assign out_byte     = queue[rd_ptr].data;
  assign status_value = signed'(queue[rd_ptr].status);
  assign complete     = queue[rd_ptr].comp;
  assign last_result  = queue[rd_ptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && bytes_remaining == 32'd0 |=> frame_phase == PH_TYPE && resp_ok)
    else $error("parser not restarted after last byte");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    frame_phase == PH_PAYLOAD |-> payload_left != 32'd0)
    else $error("payload phase with no bytes left");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    accept && bytes_remaining == 32'd0 |=> out_valid)
    else $error("end result missing");

endmodule
